/* rtl/assert_macros.svh */
// Assertion macros shared by the packed genotype dot product RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a custom message, disabled during reset.
`define ASSERT_AT_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property with a generic message.
`define ASSERT_AT(label, clk, rst, prop) \
   `ASSERT_AT_MSG(label, clk, rst, prop, "pgdp assertion failed")

`endif

/* rtl/pgdp_pkg.sv */
// Package: widths, genotype codes and stage types for the genotype dot product.
`default_nettype none

package pgdp_pkg;

   localparam int unsigned SUM_W       = 48;
   localparam int unsigned WEIGHT_W    = 32;
   localparam int unsigned MEAN_W      = 16;
   localparam int unsigned DOT_W       = 64;
   localparam int unsigned IMPUTE_FRAC = 14;

   localparam logic signed [DOT_W-1:0] IMPUTE_ROUND = DOT_W'(64'sd1 <<< (IMPUTE_FRAC - 1));

   typedef enum logic [1:0] {
      GENO_NONE = 2'd0,
      GENO_ONE  = 2'd1,
      GENO_TWO  = 2'd2,
      GENO_MISS = 2'd3
   } geno_code_type;

   // Final sums of one column plus its imputation mean.
   typedef struct packed {
      logic signed [SUM_W-1:0] sum_one;
      logic signed [SUM_W-1:0] sum_two;
      logic signed [SUM_W-1:0] sum_miss;
      logic [MEAN_W-1:0]       mean;
   } fin_type;

endpackage

`default_nettype wire

/* rtl/pgdp_ifs.sv */
// Request and response channel interfaces of the genotype dot product.
`default_nettype none

interface pgdp_req_if import pgdp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 geno_code;
   logic signed [WEIGHT_W-1:0] weight;
   logic [MEAN_W-1:0]          mean_impute;
   logic                       last_sample;

   modport source (output valid, geno_code, weight, mean_impute, last_sample, input ready);
   modport sink   (input valid, geno_code, weight, mean_impute, last_sample, output ready);
endinterface

interface pgdp_rsp_if import pgdp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DOT_W-1:0] dot_value;

   modport source (output valid, dot_value, input ready);
   modport sink   (input valid, dot_value, output ready);
endinterface

`default_nettype wire

/* rtl/packed_genotype_dot_product.sv */
// Top level: streaming two-bit genotype column dot product with mean imputation.
//
//   channel   dir  fields                                            width
//   req_bus   in   geno_code, weight, mean_impute, last_sample       2/32/16/1
//   rsp_bus   out  dot_value                                         64
//
// One beat per cycle sustained except while a last beat is held; each non-last
// beat is accumulated in the cycle after it is taken. A column result passes
// through the input, sum-capture, multiply and result registers.
// Synchronous reset clears the three sums and all valid flags.
// A stalled result backs up through the capture and multiply stages; only a
// last beat can be held in the input register, other beats keep flowing.
`default_nettype none

module packed_genotype_dot_product import pgdp_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   pgdp_req_if.sink   req_bus,
   pgdp_rsp_if.source rsp_bus
);

   fin_type fin;
   logic    fin_valid;
   logic    fin_ready;

   pgdp_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .fin       (fin),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready)
   );

   pgdp_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .fin       (fin),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

/* rtl/pgdp_accum.sv */
// Input register and per-code running sums; hands finished column sums downstream.
`default_nettype none

`include "assert_macros.svh"

module pgdp_accum import pgdp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   pgdp_req_if.sink    req_bus,
   output fin_type     fin,
   output logic        fin_valid,
   input  wire logic   fin_ready
);

   logic                       in_vld_ff;
   geno_code_type              in_code_ff;
   logic signed [WEIGHT_W-1:0] in_weight_ff;
   logic [MEAN_W-1:0]          in_mean_ff;
   logic                       in_last_ff;

   logic signed [SUM_W-1:0] sum_one_ff,  sum_one_in;
   logic signed [SUM_W-1:0] sum_two_ff,  sum_two_in;
   logic signed [SUM_W-1:0] sum_miss_ff, sum_miss_in;
   logic signed [SUM_W-1:0] sum_sel, sum_add, weight_ext;

   fin_type fin_ff;
   logic    fin_vld_ff;
   logic    in_move;

   // Non-last beats only touch the sums and never wait.
   assign in_move       = in_vld_ff && (!in_last_ff || !fin_vld_ff || fin_ready);
   assign req_bus.ready = !in_vld_ff || in_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_vld_ff <= req_bus.valid;
      end
      if (req_bus.ready && req_bus.valid) begin
         in_code_ff   <= geno_code_type'(req_bus.geno_code);
         in_weight_ff <= req_bus.weight;
         in_mean_ff   <= req_bus.mean_impute;
         in_last_ff   <= req_bus.last_sample;
      end
   end

   // One shared adder; the code picks which sum it feeds.
   always_comb begin
      weight_ext = SUM_W'(in_weight_ff);
      case (in_code_ff)
         GENO_ONE: sum_sel = sum_one_ff;
         GENO_TWO: sum_sel = sum_two_ff;
         default:  sum_sel = sum_miss_ff;
      endcase
      sum_add     = sum_sel + weight_ext;
      sum_one_in  = (in_code_ff == GENO_ONE)  ? sum_add : sum_one_ff;
      sum_two_in  = (in_code_ff == GENO_TWO)  ? sum_add : sum_two_ff;
      sum_miss_in = (in_code_ff == GENO_MISS) ? sum_add : sum_miss_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_one_ff  <= '0;
         sum_two_ff  <= '0;
         sum_miss_ff <= '0;
      end else if (in_move) begin
         if (in_last_ff) begin
            sum_one_ff  <= '0;
            sum_two_ff  <= '0;
            sum_miss_ff <= '0;
         end else begin
            sum_one_ff  <= sum_one_in;
            sum_two_ff  <= sum_two_in;
            sum_miss_ff <= sum_miss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (in_move && in_last_ff) begin
         fin_vld_ff <= 1'b1;
      end else if (fin_ready) begin
         fin_vld_ff <= 1'b0;
      end
      if (in_move && in_last_ff) begin
         fin_ff.sum_one  <= sum_one_in;
         fin_ff.sum_two  <= sum_two_in;
         fin_ff.sum_miss <= sum_miss_in;
         fin_ff.mean     <= in_mean_ff;
      end
   end

   assign fin       = fin_ff;
   assign fin_valid = fin_vld_ff;

   `ASSERT_AT_MSG(a_clear_after_last, clock, reset,
      in_move && in_last_ff |=> sum_one_ff == '0 && sum_two_ff == '0 && sum_miss_ff == '0,
      "sums not cleared after last beat")
   `ASSERT_AT(a_fin_hold, clock, reset,
      fin_vld_ff && !fin_ready |=> fin_vld_ff && $stable(fin_ff))
   `ASSERT_AT(a_none_keeps_sums, clock, reset,
      in_move && !in_last_ff && in_code_ff == GENO_NONE
         |=> $stable(sum_one_ff) && $stable(sum_two_ff) && $stable(sum_miss_ff))

endmodule

`default_nettype wire

/* rtl/pgdp_combine.sv */
// Imputation multiply and final combine of column sums into the result register.
`default_nettype none

`include "assert_macros.svh"

module pgdp_combine import pgdp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire fin_type fin,
   input  wire logic    fin_valid,
   output logic         fin_ready,
   pgdp_rsp_if.source   rsp_bus
);

   logic                    mul_vld_ff;
   logic signed [DOT_W-1:0] prod_ff, prod_in;
   logic signed [DOT_W-1:0] part_ff, part_in;
   logic signed [DOT_W:0]   prod_full;
   logic signed [MEAN_W:0]  mean_s;

   logic                    out_vld_ff;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic                    out_free;

   assign out_free  = !out_vld_ff || rsp_bus.ready;
   assign fin_ready = !mul_vld_ff || out_free;

   // Q.16 sum times unsigned Q2.14 mean gives Q.30; fits in 64 bits.
   always_comb begin
      mean_s    = signed'({1'b0, fin.mean});
      prod_full = fin.sum_miss * mean_s;
      prod_in   = prod_full[DOT_W-1:0];
      part_in   = DOT_W'(fin.sum_one) + (DOT_W'(fin.sum_two) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (fin_ready) begin
         mul_vld_ff <= fin_valid;
      end
      if (fin_ready && fin_valid) begin
         prod_ff <= prod_in;
         part_ff <= part_in;
      end
   end

   // Round to nearest, ties up, back to Q.16.
   assign dot_in = part_ff + ((prod_ff + IMPUTE_ROUND) >>> IMPUTE_FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= mul_vld_ff;
      end
      if (out_free && mul_vld_ff) begin
         dot_ff <= dot_in;
      end
   end

   assign rsp_bus.valid     = out_vld_ff;
   assign rsp_bus.dot_value = dot_ff;

   `ASSERT_AT(a_mul_to_out, clock, reset, mul_vld_ff && out_free |=> out_vld_ff)

endmodule

`default_nettype wire
